### rtl/shift_rotate_logic_unit_with_carry_macros.svh
// assertion macros shared by the shift/rotate/logic unit rtl
// no dependencies; included by files that carry concurrent checks
`ifndef SHIFT_ROTATE_LOGIC_UNIT_WITH_CARRY_MACROS_SVH
`define SHIFT_ROTATE_LOGIC_UNIT_WITH_CARRY_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SRLUC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SRLUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/srluc_pkg.sv
// types and opcode constants for the shift/rotate/logic unit
// no dependencies; imported by the interfaces and the top level
`timescale 1ns / 1ps

package srluc_pkg;

	localparam int OP_W  = 4;
	localparam int VAL_W = 8;
	localparam int CNT_W = 4;
	localparam int RES_W = 8;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [RES_W-1:0] res_t;

	localparam op_t OP_NOT = 4'd0;
	localparam op_t OP_AND = 4'd1;
	localparam op_t OP_OR  = 4'd2;
	localparam op_t OP_XOR = 4'd3;
	localparam op_t OP_SHR = 4'd4;
	localparam op_t OP_SHL = 4'd5;
	localparam op_t OP_ROL = 4'd6;
	localparam op_t OP_ROR = 4'd7;
	localparam op_t OP_SAR = 4'd8;
	localparam op_t OP_RCL = 4'd9;
	localparam op_t OP_RCR = 4'd10;

endpackage

### rtl/srluc_if.sv
// valid/ready channel interfaces for command and result beats
// depends on srluc_pkg
`timescale 1ns / 1ps

interface srluc_cmd_if import srluc_pkg::*;;
	logic valid;
	logic ready;
	op_t  op;
	val_t operand_value;
	cnt_t shift_count;

	modport source (output valid, op, operand_value, shift_count, input ready);
	modport sink (input valid, op, operand_value, shift_count, output ready);
endinterface

interface srluc_res_if import srluc_pkg::*;;
	logic valid;
	logic ready;
	res_t result_value;
	logic carry_out;

	modport source (output valid, result_value, carry_out, input ready);
	modport sink (input valid, result_value, carry_out, output ready);
endinterface

### rtl/shift_rotate_logic_unit_with_carry.sv
// shift/rotate/logic unit with carry on a DATA_WIDTH-bit accumulator
// depends on srluc_pkg, srluc_if and the assertion macro header
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------
//  cmd     | in  | op, operand_value, shift_count
//  res     | out | result_value, carry_out
//
// a command is captured in the input register, then the operation result lands
// in the accumulator, which doubles as the result register. sustained rate is
// one beat per clock when res is ready, set by the single accumulator feedback loop.
// arst_n clears accumulator, carry and both valid flags; no result is pending.
// a stalled result holds the accumulator; one more command is taken into the
// input register meanwhile, and it waits there until the result is taken.
`timescale 1ns / 1ps
`include "shift_rotate_logic_unit_with_carry_macros.svh"

module shift_rotate_logic_unit_with_carry import srluc_pkg::*; #(
	parameter int DATA_WIDTH = 8
) (
	input logic          clk,
	input logic          arst_n,
	srluc_cmd_if.sink    cmd,
	srluc_res_if.source  res
);

	localparam int RES_BITS = $clog2(DATA_WIDTH + 2);
	localparam int SW = (RES_BITS > CNT_W) ? RES_BITS : CNT_W;
	localparam logic [SW-1:0] MOD_ROT = SW'(DATA_WIDTH);
	localparam logic [SW-1:0] MOD_RCX = SW'(DATA_WIDTH + 1);

	// input register
	logic                  valid_s1;
	op_t                   op_s1;
	val_t                  val_s1;
	cnt_t                  cnt_s1;

	// accumulator state, also the result register
	logic                  valid_s2;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  carry_q;

	logic                  s2_free;
	logic                  adv;

	logic [DATA_WIDTH-1:0]   operand;
	logic [SW-1:0]           rot_n;
	logic [SW-1:0]           rcx_n;
	logic [DATA_WIDTH:0]     shr_t;
	logic [DATA_WIDTH:0]     shl_t;
	logic [DATA_WIDTH:0]     sar_t;
	logic [DATA_WIDTH:0]     rcx_v;
	logic [2*DATA_WIDTH-1:0] rol_t;
	logic [2*DATA_WIDTH-1:0] ror_t;
	logic [2*DATA_WIDTH+1:0] rcl_t;
	logic [2*DATA_WIDTH+1:0] rcr_t;
	logic [DATA_WIDTH-1:0]   acc_d;
	logic                    carry_d;

	assign s2_free   = !valid_s2 || res.ready;
	assign adv       = valid_s1 && s2_free;
	assign cmd.ready = !valid_s1 || s2_free;

	assign res.valid        = valid_s2;
	assign res.result_value = RES_W'(acc_q);
	assign res.carry_out    = carry_q;

	// count reduced modulo width and width+1, at most three subtracts for a 4-bit count
	always_comb begin
		rot_n = SW'(cnt_s1);
		rcx_n = SW'(cnt_s1);
		for (int k = 0; k < 3; k++) begin
			if (rot_n >= MOD_ROT) begin
				rot_n = rot_n - MOD_ROT;
			end
			if (rcx_n >= MOD_RCX) begin
				rcx_n = rcx_n - MOD_RCX;
			end
		end
	end

	assign operand = DATA_WIDTH'(val_s1);
	assign rcx_v   = {carry_q, acc_q};

	// low guard bit catches the last bit shifted out on right shifts
	assign shr_t = {acc_q, 1'b0} >> cnt_s1;
	assign sar_t = $unsigned($signed({acc_q, 1'b0}) >>> cnt_s1);
	assign shl_t = {1'b0, acc_q} << cnt_s1;
	assign rol_t = {acc_q, acc_q} << rot_n;
	assign ror_t = {acc_q, acc_q} >> rot_n;
	assign rcl_t = {rcx_v, rcx_v} << rcx_n;
	assign rcr_t = {rcx_v, rcx_v} >> rcx_n;

	always_comb begin
		acc_d   = acc_q;
		carry_d = carry_q;
		case (op_s1)
			OP_NOT: begin
				acc_d = ~acc_q;
			end
			OP_AND: begin
				acc_d   = acc_q & operand;
				carry_d = 1'b0;
			end
			OP_OR: begin
				acc_d   = acc_q | operand;
				carry_d = 1'b0;
			end
			OP_XOR: begin
				acc_d   = acc_q ^ operand;
				carry_d = 1'b0;
			end
			OP_SHR: begin
				if (cnt_s1 != '0) begin
					acc_d   = shr_t[DATA_WIDTH:1];
					carry_d = shr_t[0];
				end
			end
			OP_SAR: begin
				if (cnt_s1 != '0) begin
					acc_d   = sar_t[DATA_WIDTH:1];
					carry_d = sar_t[0];
				end
			end
			OP_SHL: begin
				if (cnt_s1 != '0) begin
					acc_d   = shl_t[DATA_WIDTH-1:0];
					carry_d = shl_t[DATA_WIDTH];
				end
			end
			OP_ROL: begin
				if (cnt_s1 != '0) begin
					acc_d   = rol_t[2*DATA_WIDTH-1:DATA_WIDTH];
					carry_d = rol_t[DATA_WIDTH];
				end
			end
			OP_ROR: begin
				if (cnt_s1 != '0) begin
					acc_d   = ror_t[DATA_WIDTH-1:0];
					carry_d = ror_t[DATA_WIDTH-1];
				end
			end
			OP_RCL: begin
				if (cnt_s1 != '0) begin
					acc_d   = rcl_t[2*DATA_WIDTH:DATA_WIDTH+1];
					carry_d = rcl_t[2*DATA_WIDTH+1];
				end
			end
			OP_RCR: begin
				if (cnt_s1 != '0) begin
					acc_d   = rcr_t[DATA_WIDTH-1:0];
					carry_d = rcr_t[DATA_WIDTH];
				end
			end
			default: begin
				acc_d   = acc_q;
				carry_d = carry_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1  <= cmd.op;
			val_s1 <= cmd.operand_value;
			cnt_s1 <= cmd.shift_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= '0;
			carry_q  <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
			acc_q    <= acc_d;
			carry_q  <= carry_d;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	`SRLUC_ASSERT_NEXT(a_state_holds, clk, arst_n, !adv, $stable(acc_q) && $stable(carry_q), "state moved without a beat")
	`SRLUC_ASSERT_NEXT(a_logic_clears_carry, clk, arst_n, adv && (op_s1 == OP_AND || op_s1 == OP_OR || op_s1 == OP_XOR), !carry_q, "logic op left carry set")
	`SRLUC_ASSERT_NEXT(a_not_inverts, clk, arst_n, adv && op_s1 == OP_NOT, acc_q == ~$past(acc_q) && carry_q == $past(carry_q), "not op result wrong")
	`SRLUC_ASSERT_NEXT(a_result_posted, clk, arst_n, adv, valid_s2, "beat finished without a result")
	`SRLUC_ASSERT_SAME(a_empty_takes, clk, arst_n, !valid_s1, cmd.ready, "empty input stage refused a beat")

endmodule

### dv/shift_rotate_logic_unit_with_carry_tb.sv
// testbench for the shift/rotate/logic unit with carry: a directed table, then random beats
// with random gaps and stalls on both channels, checked beat by beat against an 8-bit predictor
// depends on srluc_pkg, srluc_if and shift_rotate_logic_unit_with_carry
`timescale 1ns / 1ps

module shift_rotate_logic_unit_with_carry_tb;
	import srluc_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_BEATS = 600;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		res_t value;
		logic carry;
	} acc_beat_t;

	typedef struct {
		op_t  op;
		val_t operand;
		cnt_t count;
		bit   typed;
		res_t exp_value;
		logic exp_carry;
	} table_row_t;

	logic clk;
	logic arst_n;

	srluc_cmd_if cmd_bus ();
	srluc_res_if res_bus ();

	shift_rotate_logic_unit_with_carry #(
		.DATA_WIDTH(8)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_bus),
		.res   (res_bus)
	);

	// predictor copy of the accumulator and carry
	res_t acc_model;
	logic carry_model;

	acc_beat_t pending_results[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        calm;

	// directed beats; typed expectations start from the reset state
	table_row_t directed[] = '{
		'{OP_NOT, 8'h00, 4'd1,  1'b1, 8'hFF, 1'b0},
		'{OP_SHL, 8'h00, 4'd1,  1'b1, 8'hFE, 1'b1},
		'{OP_SHR, 8'h00, 4'd8,  1'b1, 8'h00, 1'b1},
		'{OP_OR,  8'h80, 4'd1,  1'b1, 8'h80, 1'b0},
		'{OP_SAR, 8'h00, 4'd15, 1'b1, 8'hFF, 1'b1},
		'{OP_AND, 8'h00, 4'd1,  1'b1, 8'h00, 1'b0},
		'{OP_XOR, 8'hFF, 4'd1,  1'b1, 8'hFF, 1'b0},
		'{OP_ROL, 8'h00, 4'd0,  1'b1, 8'hFF, 1'b0},
		'{OP_SHL, 8'h00, 4'd15, 1'b1, 8'h00, 1'b0},
		'{op_t'(4'hF), 8'hAA, 4'd3, 1'b1, 8'h00, 1'b0},
		'{OP_OR,  8'h81, 4'd1,  1'b1, 8'h81, 1'b0},
		'{OP_ROL, 8'h00, 4'd1,  1'b1, 8'h03, 1'b1},
		'{OP_ROR, 8'h00, 4'd1,  1'b1, 8'h81, 1'b1},
		'{OP_RCL, 8'h00, 4'd9,  1'b1, 8'h81, 1'b1},
		'{OP_RCR, 8'h00, 4'd1,  1'b0, 8'h00, 1'b0},
		'{OP_RCL, 8'h00, 4'd3,  1'b0, 8'h00, 1'b0},
		'{OP_RCR, 8'h00, 4'd12, 1'b0, 8'h00, 1'b0},
		'{OP_ROR, 8'h00, 4'd13, 1'b0, 8'h00, 1'b0},
		'{OP_SAR, 8'h00, 4'd3,  1'b0, 8'h00, 1'b0},
		'{OP_SHR, 8'h00, 4'd1,  1'b0, 8'h00, 1'b0},
		'{OP_XOR, 8'h5A, 4'd1,  1'b0, 8'h00, 1'b0},
		'{op_t'(4'hB), 8'h33, 4'd7, 1'b0, 8'h00, 1'b0},
		'{OP_RCL, 8'h00, 4'd0,  1'b0, 8'h00, 1'b0},
		'{OP_ROL, 8'h00, 4'd8,  1'b0, 8'h00, 1'b0},
		'{OP_AND, 8'hFF, 4'd1,  1'b0, 8'h00, 1'b0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic acc_beat_t alu_step(op_t op, val_t operand, cnt_t count);
		res_t      a;
		logic      c;
		logic      t;
		acc_beat_t r;
		a = acc_model;
		c = carry_model;
		case (op)
		OP_NOT: a = ~a;
		OP_AND: begin a = a & operand; c = 1'b0; end
		OP_OR:  begin a = a | operand; c = 1'b0; end
		OP_XOR: begin a = a ^ operand; c = 1'b0; end
		OP_SHR: for (int i = 0; i < count; i++) begin
			c = a[0];
			a = {1'b0, a[RES_W-1:1]};
		end
		OP_SHL: for (int i = 0; i < count; i++) begin
			c = a[RES_W-1];
			a = {a[RES_W-2:0], 1'b0};
		end
		OP_ROL: for (int i = 0; i < count; i++) begin
			c = a[RES_W-1];
			a = {a[RES_W-2:0], a[RES_W-1]};
		end
		OP_ROR: for (int i = 0; i < count; i++) begin
			c = a[0];
			a = {a[0], a[RES_W-1:1]};
		end
		OP_SAR: for (int i = 0; i < count; i++) begin
			c = a[0];
			a = {a[RES_W-1], a[RES_W-1:1]};
		end
		// nine-bit rotates through the carry
		OP_RCL: for (int i = 0; i < count; i++) begin
			t = a[RES_W-1];
			a = {a[RES_W-2:0], c};
			c = t;
		end
		OP_RCR: for (int i = 0; i < count; i++) begin
			t = a[0];
			a = {c, a[RES_W-1:1]};
			c = t;
		end
		default: ;
		endcase
		acc_model   = a;
		carry_model = c;
		r.value = a;
		r.carry = c;
		return r;
	endfunction

	function automatic int draw_wait();
		if (calm)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic send_beat(input op_t op, input val_t operand, input cnt_t count,
			input bit typed, input res_t exp_value, input logic exp_carry);
		acc_beat_t want;
		int        gap;
		gap = draw_wait();
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid         <= 1'b1;
		cmd_bus.op            <= op;
		cmd_bus.operand_value <= operand;
		cmd_bus.shift_count   <= count;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		want = alu_step(op, operand, count);
		if (typed) begin
			want.value = exp_value;
			want.carry = exp_carry;
		end
		pending_results.push_back(want);
	endtask

	// result side: random stall before each beat
	initial begin
		int stall;
		res_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!res_bus.valid)
				@(posedge clk);
		end
	end

	// result check
	always @(posedge clk) begin
		acc_beat_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %02h carry %0b",
					res_bus.result_value, res_bus.carry_out));
			end else begin
				want = pending_results.pop_front();
				if (res_bus.result_value !== want.value)
					report_mismatch($sformatf("result_value %02h, want %02h",
						res_bus.result_value, want.value));
				if (res_bus.carry_out !== want.carry)
					report_mismatch($sformatf("carry_out %0b, want %0b",
						res_bus.carry_out, want.carry));
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		op_t  op;
		cnt_t count;
		calm        = 1'b0;
		acc_model   = '0;
		carry_model = 1'b0;
		arst_n = 1'b0;
		cmd_bus.valid         <= 1'b0;
		cmd_bus.op            <= OP_NOT;
		cmd_bus.operand_value <= '0;
		cmd_bus.shift_count   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_beat(directed[i].op, directed[i].operand, directed[i].count,
				directed[i].typed, directed[i].exp_value, directed[i].exp_carry);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// alternate stretches of back-to-back beats with stretches of random gaps
			if (n % 100 == 0)
				calm = (n % 200 == 100);
			// hold off until the result side has drained
			if (n == RANDOM_BEATS / 2) begin
				cmd_bus.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				op = op_t'($urandom_range(OP_RCR + 1, {OP_W{1'b1}}));
			else
				op = op_t'($urandom_range(OP_NOT, OP_RCR));
			if ($urandom_range(0, 5) == 0)
				count = cnt_t'($urandom_range(0, {CNT_W{1'b1}}));
			else
				count = cnt_t'($urandom_range(1, RES_W));
			send_beat(op, val_t'($urandom_range(0, 255)), count, 1'b0, '0, 1'b0);
		end
		cmd_bus.valid <= 1'b0;

		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
